/* design/page_allocator_deferred_reclaim_top_macros.svh */
// Assertion macros for the page allocator
`ifndef PAGE_ALLOCATOR_DEFERRED_RECLAIM_TOP_MACROS_SVH
`define PAGE_ALLOCATOR_DEFERRED_RECLAIM_TOP_MACROS_SVH
`ifndef SYNTH
`define PA_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
`define PA_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PA_ASSERT_IMP(label, clk, rstn, ante, cons, msg)
`define PA_ASSERT_NXT(label, clk, rstn, ante, cons, msg)
`endif
`endif

/* design/pgalloc_pkg.sv */
package pgalloc_pkg;

    localparam int PAGE_W    = 11;
    localparam int MAX_PAGES = 1024;

    typedef enum logic [2:0] {
        OP_ALLOC  = 3'd0,
        OP_FREE   = 3'd1,
        OP_WRITE  = 3'd2,
        OP_READ   = 3'd3,
        OP_COMMIT = 3'd4,
        OP_FLUSH  = 3'd5
    } op_t;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_BAD   = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam logic [1:0] MODE_NONE  = 2'd0;
    localparam logic [1:0] MODE_SYNC  = 2'd1;
    localparam logic [1:0] MODE_BATCH = 2'd2;

    localparam logic       CFG_MODE     = 1'b0;
    localparam logic       CFG_INTERVAL = 1'b1;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;     // latch input item, issue memory reads
        logic execute;     // apply the item using read data
        logic flush_start; // begin moving pending entries
        logic flush_step;  // move one pending entry
        logic flush_end;   // finish the flush
        logic out_load;    // load result register
    } pa_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic need_flush;  // executed item triggers a flush with buffered meta
        logic flush_more;  // pending entries remain to move
    } pa_stat_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [PAGE_W-1:0] page_out;
        logic              appended;
        logic              cache_hit;
        logic              meta_written;
        logic              meta_slot_out;
        logic [1:0]        sync_requests;
    } pa_result_t;

endpackage

/* design/pgalloc_ctrl.sv */
`include "page_allocator_deferred_reclaim_top_macros.svh"
module pgalloc_ctrl
    import pgalloc_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    output logic     m_tvalid,
    input  logic     m_tready,
    input  pa_stat_t stat,
    output pa_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE, S_EXEC, S_FLUSH, S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    // Output register frees up once taken; load it only while free
    logic out_free;
    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_tready;
        cmd          = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC: begin
                cmd.execute = 1'b1;
                if (stat.need_flush) begin
                    cmd.flush_start = 1'b1;
                    state_next      = S_FLUSH;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_FLUSH: begin
                if (stat.flush_more) begin
                    cmd.flush_step = 1'b1;
                end else begin
                    cmd.flush_end = 1'b1;
                    state_next    = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Hold state and result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    `PA_ASSERT_NXT(a_cap_exec, aclk, aresetn, cmd.capture, state_reg == S_EXEC, "capture not followed by execute")
    `PA_ASSERT_IMP(a_load_free, aclk, aresetn, cmd.out_load, out_free, "result overwritten")
    `PA_ASSERT_NXT(a_load_valid, aclk, aresetn, cmd.out_load, m_tvalid, "loaded result not valid")

endmodule

/* design/pgalloc_dp.sv */
`include "page_allocator_deferred_reclaim_top_macros.svh"
module pgalloc_dp
    import pgalloc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic              cfg_addr,
    input  logic [15:0]       cfg_wdata,
    input  logic [2:0]        in_op,
    input  logic [PAGE_W-1:0] in_page,
    input  logic              in_slot,
    input  pa_cmd_t           cmd,
    output pa_stat_t          stat,
    output pa_result_t        result
);

    localparam int AW = $clog2(MAX_PAGES);
    localparam int CW = AW + 1;

    // Storage: live bitmap, free stack, pending list
    logic              live_mem  [MAX_PAGES];
    logic [PAGE_W-1:0] free_mem  [MAX_PAGES];
    logic [PAGE_W-1:0] pend_mem  [MAX_PAGES];

    // Stack fill counts and page count (live-map rows from it up are masked)
    logic [CW-1:0]     free_cnt_reg, pend_cnt_reg, total_reg;
    logic [PAGE_W-1:0] cached_reg;
    logic              durable_reg, meta_pend_reg;
    logic [15:0]       commits_reg;
    logic [1:0]        mode_reg;
    logic [15:0]       interval_reg;
    logic [CW-1:0]     walk_reg;

    logic [2:0]        op_reg;
    logic [PAGE_W-1:0] page_reg;
    logic              slot_reg;
    logic              live_rd_reg;
    logic [PAGE_W-1:0] top_rd_reg, pend_rd_reg;
    pa_result_t        res_reg, out_reg;

    logic [1:0] mode;
    assign mode = (mode_reg == 2'd3) ? MODE_NONE : mode_reg;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= MODE_NONE;
            interval_reg <= 16'd16;
        end else if (cfg_we) begin
            if (cfg_addr == CFG_MODE) mode_reg <= cfg_wdata[1:0];
            else                      interval_reg <= cfg_wdata;
        end
    end

    // Address decode for the read cycle
    logic [AW-1:0] live_ra, top_ra;
    logic          in_range_c;
    logic [CW-1:0] page_ext;
    assign page_ext   = CW'(in_page);
    assign in_range_c = (in_page != '0) && (page_ext <= total_reg);
    assign live_ra    = AW'(in_page - 1'b1);
    assign top_ra     = AW'(free_cnt_reg - 1'b1);

    logic live_raw;

    // Capture item and perform registered memory reads
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg      <= in_op;
            page_reg    <= in_page;
            slot_reg    <= in_slot;
            live_rd_reg <= live_mem[live_ra] && in_range_c;
            top_rd_reg  <= free_mem[top_ra];
        end
        pend_rd_reg <= pend_mem[AW'(walk_reg)];
    end
    assign live_raw = live_rd_reg;

    // Execute stage: decide state updates and result
    logic          in_range;
    logic [CW-1:0] page_e;
    logic [15:0]   commits_inc;
    logic          batch_flush;
    assign page_e      = CW'(page_reg);
    assign in_range    = (page_reg != '0) && (page_e <= total_reg);
    assign commits_inc = (commits_reg != 16'hFFFF) ? commits_reg + 16'd1 : commits_reg;
    assign batch_flush = (op_reg == OP_COMMIT && mode == MODE_BATCH &&
                          commits_inc >= interval_reg) || (op_reg == OP_FLUSH);
    assign stat.need_flush = batch_flush && (meta_pend_reg || op_reg == OP_COMMIT);
    assign stat.flush_more = (walk_reg < pend_cnt_reg);

    logic              live_we, live_wd, free_push, free_pop, pend_push;
    logic [AW-1:0]     live_wa;
    logic [PAGE_W-1:0] free_wd;
    logic [PAGE_W-1:0] alloc_page;
    pa_result_t        r;

    always_comb begin
        r          = '0;
        live_we    = 1'b0;
        live_wd    = 1'b0;
        live_wa    = AW'(page_reg - 1'b1);
        free_push  = 1'b0;
        free_pop   = 1'b0;
        pend_push  = 1'b0;
        free_wd    = page_reg;
        alloc_page = PAGE_W'(total_reg + 1'b1);
        case (op_reg)
            OP_ALLOC: begin
                if (free_cnt_reg != '0) begin
                    free_pop   = 1'b1;
                    r.page_out = top_rd_reg;
                    if (top_rd_reg != '0 && CW'(top_rd_reg) <= CW'(MAX_PAGES)) begin
                        live_we = 1'b1;
                        live_wd = 1'b1;
                        live_wa = AW'(top_rd_reg - 1'b1);
                    end
                end else if (total_reg >= CW'(MAX_PAGES)) begin
                    r.status = ST_FULL;
                end else begin
                    live_we    = 1'b1;
                    live_wd    = 1'b1;
                    live_wa    = AW'(total_reg);
                    r.page_out = alloc_page;
                    r.appended = 1'b1;
                end
            end
            OP_FREE: begin
                if (!in_range || !live_raw) begin
                    r.status = ST_BAD;
                end else begin
                    live_we = 1'b1;
                    if (mode == MODE_BATCH) pend_push = 1'b1;
                    else                    free_push = 1'b1;
                end
            end
            OP_WRITE: begin
                if (!in_range) begin
                    r.status = ST_BAD;
                end else begin
                    live_we = 1'b1;
                    live_wd = 1'b1;
                    if (mode == MODE_SYNC) r.sync_requests = 2'd1;
                end
            end
            OP_READ: begin
                if (!in_range || !live_raw) r.status = ST_BAD;
                else if (cached_reg == page_reg) r.cache_hit = 1'b1;
            end
            OP_COMMIT: begin
                if (mode != MODE_BATCH) begin
                    r.meta_written  = 1'b1;
                    r.meta_slot_out = slot_reg;
                    if (mode == MODE_SYNC) r.sync_requests = 2'd1;
                end
            end
            OP_FLUSH: ;
            default: r.status = ST_BAD;
        endcase
        // A flush with buffered meta writes the other slot and asks for two syncs
        if (cmd.flush_start) begin
            r.meta_written  = 1'b1;
            r.meta_slot_out = !durable_reg;
            r.sync_requests = 2'd2;
        end
    end

    // Apply execute updates, then flush walk
    always_ff @(posedge aclk) begin
        if (cmd.execute && live_we) live_mem[live_wa] <= live_wd;
        if (cmd.execute && free_push && free_cnt_reg < CW'(MAX_PAGES))
            free_mem[AW'(free_cnt_reg)] <= free_wd;
        else if (cmd.flush_step && free_cnt_reg < CW'(MAX_PAGES))
            free_mem[AW'(free_cnt_reg)] <= pend_rd_reg;
        if (cmd.execute && pend_push && pend_cnt_reg < CW'(MAX_PAGES))
            pend_mem[AW'(pend_cnt_reg)] <= page_reg;
    end

    // Registered pend_mem read: the walk advances on alternate flush steps
    logic walk_ph_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            free_cnt_reg  <= '0;
            pend_cnt_reg  <= '0;
            total_reg     <= '0;
            cached_reg    <= '0;
            durable_reg   <= 1'b0;
            meta_pend_reg <= 1'b0;
            commits_reg   <= '0;
            walk_reg      <= '0;
            walk_ph_reg   <= 1'b0;
        end else begin
            if (cmd.execute) begin
                res_reg <= r;
                if (free_pop) free_cnt_reg <= free_cnt_reg - 1'b1;
                if (free_push && free_cnt_reg < CW'(MAX_PAGES))
                    free_cnt_reg <= free_cnt_reg + 1'b1;
                if (pend_push && pend_cnt_reg < CW'(MAX_PAGES))
                    pend_cnt_reg <= pend_cnt_reg + 1'b1;
                if (op_reg == OP_ALLOC && free_cnt_reg == '0 && r.appended)
                    total_reg <= total_reg + 1'b1;
                if (op_reg == OP_ALLOC && free_pop && cached_reg == top_rd_reg)
                    cached_reg <= '0;
                if ((op_reg == OP_FREE || op_reg == OP_WRITE) && r.status == ST_OK
                    && cached_reg == page_reg)
                    cached_reg <= '0;
                if (op_reg == OP_READ && r.status == ST_OK && !r.cache_hit)
                    cached_reg <= page_reg;
                if (op_reg == OP_COMMIT && mode == MODE_BATCH) begin
                    meta_pend_reg <= 1'b1;
                    commits_reg   <= batch_flush ? 16'd0 : commits_inc;
                end
                if (op_reg == OP_FLUSH) commits_reg <= '0;
                walk_reg    <= '0;
                walk_ph_reg <= 1'b0;
            end
            if (cmd.flush_step) begin
                walk_ph_reg <= !walk_ph_reg;
                if (walk_ph_reg) begin
                    walk_reg <= walk_reg + 1'b1;
                    if (free_cnt_reg < CW'(MAX_PAGES))
                        free_cnt_reg <= free_cnt_reg + 1'b1;
                end
            end
            if (cmd.flush_end) begin
                durable_reg   <= !durable_reg;
                meta_pend_reg <= 1'b0;
                pend_cnt_reg  <= '0;
                commits_reg   <= '0;
            end
        end
    end

    // Result register toward the stream
    always_ff @(posedge aclk) begin
        if (cmd.out_load) out_reg <= res_reg;
    end
    assign result = out_reg;

    `PA_ASSERT_IMP(a_free_bound, aclk, aresetn, 1'b1, free_cnt_reg <= CW'(MAX_PAGES), "free stack overrun")
    `PA_ASSERT_IMP(a_total_bound, aclk, aresetn, 1'b1, total_reg <= CW'(MAX_PAGES), "page count overrun")
    `PA_ASSERT_NXT(a_flush_clear, aclk, aresetn, cmd.flush_end, pend_cnt_reg == '0 && !meta_pend_reg, "flush left pending state")

endmodule

/* design/page_allocator_deferred_reclaim_top.sv */
// Page number allocator with deferred reclaim.
// Input stream s_*: tdata = {meta_slot_in, page_index, op} from bit 0 up
// (op [2:0], page_index [13:3], meta_slot_in [14]), 16 bits.
// Result stream m_*: one transaction per input transaction; tdata from bit 0:
// status [1:0], page_out [12:2], appended [13], cache_hit [14],
// meta_written [15], meta_slot_out [16], sync_requests [18:17], 24 bits.
// Configuration: cfg_we, cfg_addr (0 durability_mode, 1 flush_interval),
// cfg_wdata; write only while the block is idle.
// After acceptance the item is executed, then the result register is loaded;
// a flush with buffered meta adds the flush state between the two, which
// walks the pending list through a single registered read port, with a read
// step and a write step per pending entry.
// A new item is accepted only in idle, once the previous result is loaded.
// Reset (aresetn low, synchronous): empty store, nothing cached, slot A
// durable, mode none, flush interval 16; no clearing pass is needed since
// only live-map rows below the page count are consulted.
// A stalled receiver holds the result in the output register; the block
// finishes the next item and waits before loading it.
module page_allocator_deferred_reclaim_top
    import pgalloc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // op, page_index, meta_slot_in
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // status, page_out, appended, cache_hit,
                                   // meta_written, meta_slot_out, sync_requests
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [15:0] cfg_wdata
);

    pa_cmd_t    cmd;
    pa_stat_t   stat;
    pa_result_t res;

    pgalloc_ctrl u_ctrl (
        .aclk, .aresetn, .s_tvalid, .s_tready, .m_tvalid, .m_tready,
        .stat, .cmd
    );

    pgalloc_dp u_dp (
        .aclk, .aresetn, .cfg_we, .cfg_addr, .cfg_wdata,
        .in_op(s_tdata[2:0]), .in_page(s_tdata[13:3]), .in_slot(s_tdata[14]),
        .cmd, .stat, .result(res)
    );

    assign m_tdata = {5'd0, res.sync_requests, res.meta_slot_out, res.meta_written,
                      res.cache_hit, res.appended, res.page_out, res.status};

endmodule

/* dv/pa_checker.sv */
module pa_checker
    import pgalloc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [15:0] cfg_wdata,
    output int          fail_count,
    output int          results_waiting
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NPAGES = 1024;

    // shadow allocator state
    bit                live_pg [NPAGES];
    logic [PAGE_W-1:0] free_stk [NPAGES];
    int unsigned       free_cnt;
    logic [PAGE_W-1:0] pend_lst [NPAGES];
    int unsigned       pend_cnt;
    int unsigned       page_total;
    logic [PAGE_W-1:0] cache_tag;
    logic              durable;
    logic              meta_buf;
    logic [15:0]       commit_cnt;
    logic [1:0]        dur_mode;
    logic [15:0]       flush_ivl;

    pa_result_t expected_results [$];

    assign results_waiting = expected_results.size();

    function automatic void clear_shadow();
        foreach (live_pg[i]) live_pg[i] = 1'b0;
        free_cnt   = 0;
        pend_cnt   = 0;
        page_total = 0;
        cache_tag  = '0;
        durable    = 1'b0;
        meta_buf   = 1'b0;
        commit_cnt = '0;
        dur_mode   = MODE_NONE;
        flush_ivl  = 16'd16;
    endfunction

    function automatic void push_freed(logic [PAGE_W-1:0] pg);
        if (free_cnt < NPAGES) begin
            free_stk[free_cnt] = pg;
            free_cnt++;
        end
    endfunction

    // group commit: if meta buffered, retire pending frees, swap slot
    function automatic void group_flush(ref pa_result_t r);
        if (!meta_buf) begin
            commit_cnt = '0;
            return;
        end
        durable         = ~durable;
        r.meta_written  = 1'b1;
        r.meta_slot_out = durable;
        r.sync_requests = 2'd2;
        meta_buf        = 1'b0;
        for (int i = 0; i < pend_cnt; i++) push_freed(pend_lst[i]);
        pend_cnt   = 0;
        commit_cnt = '0;
    endfunction

    function automatic pa_result_t predict_result(logic [15:0] item);
        pa_result_t        r;
        logic [2:0]        op;
        logic [PAGE_W-1:0] pg;
        logic              slot;
        logic [1:0]        md;
        bit                valid_pg;
        r    = '0;
        op   = item[2:0];
        pg   = item[13:3];
        slot = item[14];
        md   = (dur_mode == 2'd3) ? MODE_NONE : dur_mode;
        valid_pg = (pg != 0) && (pg <= page_total);
        case (op)
            OP_ALLOC: begin
                if (free_cnt > 0) begin
                    free_cnt--;
                    r.page_out = free_stk[free_cnt];
                    if (r.page_out != 0 && r.page_out <= NPAGES)
                        live_pg[r.page_out - 1] = 1'b1;
                    if (cache_tag == r.page_out) cache_tag = '0;
                end else if (page_total >= NPAGES) begin
                    r.status = ST_FULL;
                end else begin
                    page_total++;
                    live_pg[page_total - 1] = 1'b1;
                    r.page_out = PAGE_W'(page_total);
                    r.appended = 1'b1;
                end
            end
            OP_FREE: begin
                if (!valid_pg || !live_pg[pg - 1]) begin
                    r.status = ST_BAD;
                end else begin
                    live_pg[pg - 1] = 1'b0;
                    if (md == MODE_BATCH) begin
                        if (pend_cnt < NPAGES) begin
                            pend_lst[pend_cnt] = pg;
                            pend_cnt++;
                        end
                    end else begin
                        push_freed(pg);
                    end
                    if (cache_tag == pg) cache_tag = '0;
                end
            end
            OP_WRITE: begin
                if (!valid_pg) begin
                    r.status = ST_BAD;
                end else begin
                    live_pg[pg - 1] = 1'b1;
                    if (cache_tag == pg) cache_tag = '0;
                    if (md == MODE_SYNC) r.sync_requests = 2'd1;
                end
            end
            OP_READ: begin
                if (!valid_pg || !live_pg[pg - 1]) r.status = ST_BAD;
                else if (cache_tag == pg) r.cache_hit = 1'b1;
                else cache_tag = pg;
            end
            OP_COMMIT: begin
                if (md == MODE_BATCH) begin
                    meta_buf = 1'b1;
                    if (commit_cnt != 16'hFFFF) commit_cnt++;
                    if (commit_cnt >= flush_ivl) group_flush(r);
                end else begin
                    r.meta_written  = 1'b1;
                    r.meta_slot_out = slot;
                    if (md == MODE_SYNC) r.sync_requests = 2'd1;
                end
            end
            OP_FLUSH: group_flush(r);
            default: r.status = ST_BAD;
        endcase
        return r;
    endfunction

    // track config, predict on input transactions, compare on results
    always @(posedge aclk) begin
        pa_result_t got;
        pa_result_t want;
        if (!aresetn) begin
            clear_shadow();
            expected_results.delete();
            fail_count <= 0;
        end else begin
            if (cfg_we) begin
                if (cfg_addr == CFG_MODE) dur_mode = cfg_wdata[1:0];
                else flush_ivl = cfg_wdata;
            end
            if (s_tvalid && s_tready)
                expected_results.insert(expected_results.size(), predict_result(s_tdata));
            if (m_tvalid && m_tready) begin
                got = {m_tdata[1:0], m_tdata[12:2], m_tdata[13], m_tdata[14],
                       m_tdata[15], m_tdata[16], m_tdata[18:17]};
                if (expected_results.size() == 0) begin
                    if (fail_count < 10)
                        $display("%0t: unexpected result %h", $realtime, m_tdata);
                    fail_count <= fail_count + 1;
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want || m_tdata[23:19] !== 5'd0) begin
                        if (fail_count < 10)
                            $display({"%0t: mismatch st %0d/%0d pg %0d/%0d app %0d/%0d",
                                      " hit %0d/%0d mw %0d/%0d slot %0d/%0d sync %0d/%0d"},
                                     $realtime, want.status, got.status,
                                     want.page_out, got.page_out,
                                     want.appended, got.appended,
                                     want.cache_hit, got.cache_hit,
                                     want.meta_written, got.meta_written,
                                     want.meta_slot_out, got.meta_slot_out,
                                     want.sync_requests, got.sync_requests);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

/* dv/tb.sv */
module tb;
    import pgalloc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 20000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        cfg_we = 1'b0;
    logic        cfg_addr = 1'b0;
    logic [15:0] cfg_wdata = '0;
    int          fail_count;
    int          results_waiting;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          idle_cycles = 0;
    int          sent_items = 0;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    page_allocator_deferred_reclaim_top dut (.*);

    pa_checker u_checker (.*);

    // random receiver back-pressure
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // watchdog on accepted transactions
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired");
            $display("tb: failure");
            $finish;
        end
    end

    // valid stays up after acceptance unless the sender idles or the run pauses
    task automatic send_item(logic [2:0] op, logic [PAGE_W-1:0] pg, logic slot);
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < send_idle_pct) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, slot, pg, op};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sent_items++;
    endtask

    task automatic write_reg(logic addr, logic [15:0] val);
        s_tvalid <= 1'b0;
        while (results_waiting != 0) @(posedge aclk);
        repeat (3000) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // mostly plausible pages, with out-of-range and wide values mixed in
    function automatic logic [PAGE_W-1:0] pick_page();
        int k;
        k = $urandom_range(99);
        if (k < 80) return PAGE_W'($urandom_range(32, 1));
        if (k < 90) return PAGE_W'($urandom_range(1100, 0));
        return PAGE_W'($urandom);
    endfunction

    task automatic random_burst(int n);
        int k;
        logic [2:0] op;
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(99);
            if (k < 22) op = OP_ALLOC;
            else if (k < 42) op = OP_FREE;
            else if (k < 57) op = OP_WRITE;
            else if (k < 75) op = OP_READ;
            else if (k < 88) op = OP_COMMIT;
            else if (k < 96) op = OP_FLUSH;
            else op = 3'($urandom_range(7, 6));
            send_item(op, pick_page(), 1'($urandom));
        end
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty store, extremes, every op, unused codes
        send_item(OP_READ, 11'd0, 1'b0);
        send_item(OP_FREE, 11'd1, 1'b0);
        send_item(OP_ALLOC, 11'd0, 1'b0);
        send_item(OP_ALLOC, 11'd0, 1'b0);
        send_item(OP_READ, 11'd1, 1'b0);
        send_item(OP_READ, 11'd1, 1'b0);
        send_item(OP_WRITE, 11'd1, 1'b0);
        send_item(OP_READ, 11'd2047, 1'b1);
        send_item(OP_FREE, 11'd2, 1'b0);
        send_item(OP_FREE, 11'd2, 1'b0);
        send_item(OP_WRITE, 11'd2, 1'b0);
        send_item(OP_ALLOC, 11'd0, 1'b0);
        send_item(OP_COMMIT, 11'd0, 1'b1);
        send_item(OP_COMMIT, 11'd1024, 1'b0);
        send_item(OP_FLUSH, 11'd0, 1'b0);
        send_item(3'd6, 11'd5, 1'b1);
        send_item(3'd7, 11'd2047, 1'b1);

        // batched mode with interval 1
        write_reg(CFG_MODE, {14'd0, MODE_BATCH});
        write_reg(CFG_INTERVAL, 16'd1);
        send_item(OP_FREE, 11'd1, 1'b0);
        send_item(OP_ALLOC, 11'd0, 1'b0);
        send_item(OP_COMMIT, 11'd0, 1'b0);
        send_item(OP_ALLOC, 11'd0, 1'b0);

        // fill the store to saturation, then free and reuse
        write_reg(CFG_MODE, {14'd0, MODE_NONE});
        for (int i = 0; i < 1030; i++) send_item(OP_ALLOC, 11'd0, 1'b0);
        send_item(OP_FREE, 11'd1024, 1'b0);
        send_item(OP_READ, 11'd1024, 1'b0);
        send_item(OP_ALLOC, 11'd0, 1'b0);
        for (int i = 1; i <= 40; i++) send_item(OP_FREE, 11'(i * 25), 1'b0);

        // random phases over modes and intervals, three idling regimes
        send_idle_pct = 33; recv_idle_pct = 50;
        write_reg(CFG_MODE, {14'd0, MODE_SYNC});
        random_burst(40);
        write_reg(CFG_MODE, {14'd0, MODE_BATCH});
        write_reg(CFG_INTERVAL, 16'd3);
        random_burst(50);
        send_idle_pct = 50; recv_idle_pct = 33;
        write_reg(CFG_INTERVAL, 16'hFFFF);
        random_burst(40);
        write_reg(CFG_INTERVAL, 16'd0);
        random_burst(20);
        send_idle_pct = 0; recv_idle_pct = 0;
        write_reg(CFG_MODE, 16'd3);
        random_burst(20);
        write_reg(CFG_MODE, {14'd0, MODE_BATCH});
        write_reg(CFG_INTERVAL, 16'd5);
        random_burst(30);

        s_tvalid <= 1'b0;
        while (results_waiting != 0) @(posedge aclk);
        repeat (3000) @(posedge aclk);
        $display("covered %0d items across all durability modes, flush intervals 0..65535,",
                 sent_items);
        $display("store saturation, deferred reclaim and mixed back-pressure");
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

/* page_allocator_deferred_reclaim_top.f */
+incdir+design
design/pgalloc_pkg.sv
design/pgalloc_ctrl.sv
design/pgalloc_dp.sv
design/page_allocator_deferred_reclaim_top.sv
dv/pa_checker.sv
dv/tb.sv
